>>> rtl/core/lpm_pkg.sv
// Package for the longest prefix match table: payload structs, operation
// and status codes, prefix mask and chain merge helpers. No dependencies.
`default_nettype none
package lpm_pkg;
	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_DEL    = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_DUP    = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	localparam logic [0:0] CFG_DEFAULT_IFACE = 1'd0;
	localparam logic [0:0] CFG_DEFAULT_HOP   = 1'd1;

	// cells per group of the match chain
	localparam int SEG_CELLS = 8;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [7:0]  iface_id;
		logic [31:0] next_hop;
	} in_t;

	typedef struct packed {
		logic [7:0]  route_iface;
		logic [31:0] route_next_hop;
		logic        hit;
		logic [5:0]  match_len;
		logic [1:0]  status;
	} out_t;

	// running best match passed from cell to cell
	typedef struct packed {
		logic        hit;
		logic [5:0]  len;
		logic [7:0]  iface;
		logic [31:0] hop;
		logic        key_found;
		logic        free_found;
	} chain_t;

	// command broadcast to every cell
	typedef struct packed {
		logic        add;
		logic        del;
		logic [31:0] key;
		logic [5:0]  len;
		logic [7:0]  iface;
		logic [31:0] hop;
	} wr_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		m = '0;
		if (len != 6'd0) m = 32'hFFFF_FFFF << (6'd32 - len);
		return m;
	endfunction

	// merge the result of a later group into the running one; strict greater
	// keeps the lower index on equal lengths
	function automatic chain_t merge_chain(input chain_t run, input chain_t nxt);
		chain_t m;
		m = run;
		if (nxt.hit && (!run.hit || nxt.len > run.len)) begin
			m.hit   = 1'b1;
			m.len   = nxt.len;
			m.iface = nxt.iface;
			m.hop   = nxt.hop;
		end
		m.key_found  = run.key_found || nxt.key_found;
		m.free_found = run.free_found || nxt.free_found;
		return m;
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/lpm_cell.sv
// One table entry of the match chain: compares its entry, merges into the
// running result, and applies writes. Depends on lpm_pkg.
`default_nettype none
module lpm_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    addr,
	input  wire logic [31:0]    key,
	input  wire logic [5:0]     key_len,
	input  wire lpm_pkg::chain_t chain_in,
	output lpm_pkg::chain_t     chain_out,
	input  wire lpm_pkg::wr_t   wr,
	input  wire logic           wr_sel
);
	logic        valid_q;
	logic [31:0] prefix_q;
	logic [5:0]  len_q;
	logic [7:0]  iface_q;
	logic [31:0] hop_q;
	logic        match;
	logic        key_eq;

	assign match  = valid_q && ((addr & lpm_pkg::prefix_mask(len_q)) == prefix_q);
	assign key_eq = valid_q && (prefix_q == key) && (len_q == key_len);

	always_comb begin
		chain_out = chain_in;
		// strict greater keeps the lowest index on ties, as the scan does
		if (match && (!chain_in.hit || len_q > chain_in.len)) begin
			chain_out.hit   = 1'b1;
			chain_out.len   = len_q;
			chain_out.iface = iface_q;
			chain_out.hop   = hop_q;
		end
		if (key_eq) chain_out.key_found = 1'b1;
		if (!valid_q) chain_out.free_found = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_sel && wr.add) begin
			valid_q <= 1'b1;
		end else if (wr_sel && wr.del) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel && wr.add) begin
			prefix_q <= wr.key;
			len_q    <= wr.len;
			iface_q  <= wr.iface;
			hop_q    <= wr.hop;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/lpm_segment.sv
// A group of chained cells; the running best match ripples through the
// group from its chain input. Depends on lpm_pkg and lpm_cell.
`default_nettype none
module lpm_segment #(
	parameter int CELLS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    addr,
	input  wire logic [31:0]    key,
	input  wire logic [5:0]     key_len,
	input  wire lpm_pkg::chain_t chain_in,
	output lpm_pkg::chain_t     chain_out,
	input  wire lpm_pkg::wr_t   wr,
	input  wire logic [CELLS-1:0] wr_sel,
	output logic [CELLS-1:0]    free_vec,
	output logic [CELLS-1:0]    key_vec
);
	lpm_pkg::chain_t link [CELLS+1];

	assign link[0] = chain_in;
	assign chain_out = link[CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		lpm_cell u_cell (
			.clk(clk), .arst_n(arst_n), .addr(addr), .key(key), .key_len(key_len),
			.chain_in(link[i]), .chain_out(link[i+1]),
			.wr(wr), .wr_sel(wr_sel[i])
		);
		// per-cell flags come from the step in the chain where the flag rises
		assign free_vec[i] = link[i+1].free_found && !link[i].free_found;
		assign key_vec[i]  = link[i+1].key_found && !link[i].key_found;
	end
endmodule
`default_nettype wire

>>> rtl/core/longest_prefix_match_table_core.sv
// Top level of the IPv4 longest prefix match table.
// Channels: in (valid/stall, lpm_pkg::in_t), out (valid/stall, lpm_pkg::out_t),
// configuration write port for the default route.
// Depends on lpm_pkg, lpm_segment and lpm_cell.
//
// Usage:
//  - One beat in gives exactly one beat out. Ops: lookup, add, delete.
//  - The cells are cut into groups of lpm_pkg::SEG_CELLS. After the accept,
//    state S_CMP compares inside every group and registers each group's
//    best match, S_MRG merges the groups, S_WR does the write and registers
//    the result, which then moves to the output register when that is free.
//  - No new beat is taken before the last one is through: input stalls from
//    the accept until the result has left the holding register.
//  - Reset clears every valid bit at once; the table is empty and the
//    default route is 0. No clearing sweep.
//  - A stalled result holds in the output register; while it is stalled
//    one further item may be worked on, and input stalls until it drains.
//  - Make configuration writes only while idle; the block does not enforce it.
`default_nettype none
module longest_prefix_match_table_core #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire lpm_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output lpm_pkg::out_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic [0:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);
	localparam int SEGS = (TABLE_ENTRIES + lpm_pkg::SEG_CELLS - 1) / lpm_pkg::SEG_CELLS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_MRG  = 2'd2;
	localparam logic [1:0] S_WR   = 2'd3;

	logic [1:0]        state_q;
	logic [7:0]        def_iface_q;
	logic [31:0]       def_hop_q;
	logic [1:0]        func_q;
	logic [31:0]       addr_q;
	logic [31:0]       key_q;
	logic [5:0]        len_q;
	logic [7:0]        iface_q;
	logic [31:0]       hop_q;
	lpm_pkg::chain_t   seg_s1 [SEGS];
	logic [TABLE_ENTRIES-1:0] free_s1;
	logic [TABLE_ENTRIES-1:0] keyv_s1;
	lpm_pkg::chain_t   best_s2;
	logic [TABLE_ENTRIES-1:0] ffree_s2;
	lpm_pkg::out_t     res_q;
	logic              res_valid_q;
	lpm_pkg::out_t     out_q;
	logic              out_valid_q;

	lpm_pkg::chain_t   chain_zero;
	lpm_pkg::chain_t   seg_best [SEGS];
	lpm_pkg::chain_t   mrg [SEGS+1];
	logic [TABLE_ENTRIES-1:0] free_vec;
	logic [TABLE_ENTRIES-1:0] key_vec;
	logic [TABLE_ENTRIES-1:0] wr_sel;
	logic [TABLE_ENTRIES-1:0] first_free;
	lpm_pkg::wr_t      wr;
	logic [5:0]        clen;
	logic              accept;
	logic              do_wr;
	lpm_pkg::out_t     res_d;
	logic              any_free;
	logic              any_key;

	assign clen = (in_data.prefix_len > 6'd32) ? 6'd32 : in_data.prefix_len;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || res_valid_q;

	assign chain_zero = '0;
	assign mrg[0] = '0;
	for (genvar s = 0; s < SEGS; s++) begin : g_seg
		localparam int BASE = s * lpm_pkg::SEG_CELLS;
		localparam int N = (TABLE_ENTRIES - BASE < lpm_pkg::SEG_CELLS) ?
			TABLE_ENTRIES - BASE : lpm_pkg::SEG_CELLS;
		logic pick;
		lpm_segment #(.CELLS(N)) u_seg (
			.clk(clk), .arst_n(arst_n), .addr(addr_q), .key(key_q),
			.key_len(len_q), .chain_in(chain_zero), .chain_out(seg_best[s]),
			.wr(wr), .wr_sel(wr_sel[BASE +: N]),
			.free_vec(free_vec[BASE +: N]), .key_vec(key_vec[BASE +: N])
		);
		assign mrg[s+1] = lpm_pkg::merge_chain(mrg[s], seg_s1[s]);
		// lowest free slot lies in the first group that has one
		assign pick = seg_s1[s].free_found && !mrg[s].free_found;
		assign first_free[BASE +: N] = free_s1[BASE +: N] & {N{pick}};
	end

	assign any_free = best_s2.free_found;
	assign any_key  = best_s2.key_found;

	always_comb begin
		wr       = '0;
		wr.key   = key_q;
		wr.len   = len_q;
		wr.iface = iface_q;
		wr.hop   = hop_q;
		do_wr    = (state_q == S_WR);
		wr.add   = do_wr && (func_q == lpm_pkg::FUNC_ADD) && !any_key && any_free;
		wr.del   = do_wr && (func_q == lpm_pkg::FUNC_DEL) && any_key;
		wr_sel   = '0;
		if (wr.add) wr_sel = ffree_s2;
		if (wr.del) wr_sel = keyv_s1;
	end

	always_comb begin
		res_d = '0;
		unique case (func_q)
			lpm_pkg::FUNC_LOOKUP: begin
				res_d.hit = best_s2.hit;
				if (best_s2.hit) begin
					res_d.route_iface    = best_s2.iface;
					res_d.route_next_hop = best_s2.hop;
					res_d.match_len      = best_s2.len;
				end else begin
					res_d.route_iface    = def_iface_q;
					res_d.route_next_hop = def_hop_q;
				end
			end
			lpm_pkg::FUNC_ADD: begin
				if (any_key) res_d.status = lpm_pkg::ST_DUP;
				else if (!any_free) res_d.status = lpm_pkg::ST_FULL;
			end
			lpm_pkg::FUNC_DEL: begin
				if (!any_key) res_d.status = lpm_pkg::ST_ABSENT;
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			def_iface_q <= '0;
			def_hop_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lpm_pkg::CFG_DEFAULT_IFACE: def_iface_q <= cfg_data[7:0];
					lpm_pkg::CFG_DEFAULT_HOP:   def_hop_q   <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_CMP;
				S_CMP:  state_q <= S_MRG;
				S_MRG:  state_q <= S_WR;
				S_WR:   begin
					res_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (res_valid_q && (!out_valid_q || !out_stall)) begin
				res_valid_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_data.func;
			addr_q  <= in_data.address;
			key_q   <= in_data.address & lpm_pkg::prefix_mask(clen);
			len_q   <= clen;
			iface_q <= in_data.iface_id;
			hop_q   <= in_data.next_hop;
		end
		if (state_q == S_CMP) begin
			for (int s = 0; s < SEGS; s++) seg_s1[s] <= seg_best[s];
			free_s1 <= free_vec;
			keyv_s1 <= key_vec;
		end
		if (state_q == S_MRG) begin
			best_s2  <= mrg[SEGS];
			ffree_s2 <= first_free;
		end
		if (state_q == S_WR) res_q <= res_d;
		if (res_valid_q && (!out_valid_q || !out_stall)) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

>>> rtl/core/lpm_checker.sv
// Port-level checks for the longest prefix match table core.
// Depends on lpm_pkg; bound to longest_prefix_match_table_core.
`default_nettype none
module lpm_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire lpm_pkg::out_t out_data,
	input wire logic          out_valid,
	input wire logic          out_stall
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	a_lookup_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.match_len == 6'd0)
		else $error("miss with nonzero length");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.match_len <= 6'd32)
		else $error("length out of range");
endmodule

bind longest_prefix_match_table_core lpm_checker u_lpm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);
`default_nettype wire

>>> tb/testbench.sv
// Testbench for longest_prefix_match_table_core: directed table, then random
// add/delete/lookup/no-op traffic checked against an in-bench route table model.
// Depends on lpm_pkg and the RTL of the core.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 64;
	localparam int CYCLE_LIMIT = 400000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_we;
	lpm_pkg::in_t in_data;
	lpm_pkg::out_t out_data;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;

	longest_prefix_match_table_core #(.TABLE_ENTRIES(ENTRIES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// route table copy
	bit        rt_valid[ENTRIES];
	bit [31:0] rt_prefix[ENTRIES];
	bit [5:0]  rt_len[ENTRIES];
	bit [7:0]  rt_iface[ENTRIES];
	bit [31:0] rt_hop[ENTRIES];
	bit [7:0]  dflt_iface;
	bit [31:0] dflt_hop;

	lpm_pkg::out_t route_q[$];
	int errors = 0;
	int cycles = 0;
	bit sink_hold = 0;
	bit calm = 0;

	typedef struct {
		logic [1:0]    func;
		logic [31:0]   address;
		logic [5:0]    plen;
		logic [7:0]    iface;
		logic [31:0]   hop;
		bit            typed;
		lpm_pkg::out_t want;
	} row_t;

	function automatic bit [31:0] mask_of(bit [5:0] len);
		if (len == 0) return '0;
		return ~(32'hFFFF_FFFF >> len);
	endfunction

	function automatic int find_route(bit [31:0] key, bit [5:0] len);
		for (int k = 0; k < ENTRIES; k++)
			if (rt_valid[k] && rt_prefix[k] == key && rt_len[k] == len) return k;
		return -1;
	endfunction

	function automatic lpm_pkg::out_t route_step(lpm_pkg::in_t it);
		lpm_pkg::out_t r;
		bit [5:0] len;
		bit [31:0] key;
		int best, at;
		r = '0;
		len = (it.prefix_len > 32) ? 6'd32 : it.prefix_len;
		key = it.address & mask_of(len);
		best = -1;
		case (it.func)
			lpm_pkg::FUNC_LOOKUP: begin
				for (int k = 0; k < ENTRIES; k++)
					if (rt_valid[k] && (it.address & mask_of(rt_len[k])) == rt_prefix[k])
						if (best < 0 || rt_len[k] > rt_len[best]) best = k;
				if (best >= 0) begin
					r.route_iface = rt_iface[best];
					r.route_next_hop = rt_hop[best];
					r.hit = 1'b1;
					r.match_len = rt_len[best];
				end else begin
					r.route_iface = dflt_iface;
					r.route_next_hop = dflt_hop;
				end
				r.status = lpm_pkg::ST_DONE;
			end
			lpm_pkg::FUNC_ADD: begin
				if (find_route(key, len) >= 0) r.status = lpm_pkg::ST_DUP;
				else begin
					at = -1;
					for (int k = 0; k < ENTRIES && at < 0; k++)
						if (!rt_valid[k]) at = k;
					if (at < 0) r.status = lpm_pkg::ST_FULL;
					else begin
						rt_valid[at] = 1;
						rt_prefix[at] = key;
						rt_len[at] = len;
						rt_iface[at] = it.iface_id;
						rt_hop[at] = it.next_hop;
						r.status = lpm_pkg::ST_DONE;
					end
				end
			end
			lpm_pkg::FUNC_DEL: begin
				at = find_route(key, len);
				if (at >= 0) begin
					rt_valid[at] = 0;
					r.status = lpm_pkg::ST_DONE;
				end else r.status = lpm_pkg::ST_ABSENT;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		lpm_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (route_q.size() == 0) begin
				$error("result beat with nothing expected: %p", out_data);
				errors++;
			end else begin
				want = route_q.pop_front();
				if (out_data.route_iface !== want.route_iface) begin
					$error("route_iface exp %0h got %0h", want.route_iface,
						out_data.route_iface);
					errors++;
				end
				if (out_data.route_next_hop !== want.route_next_hop) begin
					$error("route_next_hop exp %0h got %0h", want.route_next_hop,
						out_data.route_next_hop);
					errors++;
				end
				if (out_data.hit !== want.hit) begin
					$error("hit exp %0d got %0d", want.hit, out_data.hit);
					errors++;
				end
				if (out_data.match_len !== want.match_len) begin
					$error("match_len exp %0d got %0d", want.match_len, out_data.match_len);
					errors++;
				end
				if (out_data.status !== want.status) begin
					$error("status exp %0d got %0d", want.status, out_data.status);
					errors++;
				end
			end
		end
	end

	// receiver stall: random, or held during a long hold-off
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			out_stall <= sink_hold || (!calm && $urandom_range(99) < 8);
		end
	end

	task automatic wait_cycles(int n);
		repeat (n) @(negedge clk);
	endtask

	// valid stays up after the accept until the next call or an explicit drop
	task automatic send_beat(lpm_pkg::in_t it, bit typed, lpm_pkg::out_t want);
		lpm_pkg::out_t got;
		if (!calm)
			while ($urandom_range(99) < 8) begin
				in_valid <= 0;
				@(negedge clk);
			end
		in_valid <= 1;
		in_data <= it;
		got = route_step(it);
		route_q.push_back(typed ? want : got);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (route_q.size() != 0) @(negedge clk);
		wait_cycles(6);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == lpm_pkg::CFG_DEFAULT_IFACE) dflt_iface = val[7:0];
		else dflt_hop = val;
	endtask

	function automatic lpm_pkg::in_t mk(logic [1:0] f, logic [31:0] a, logic [5:0] l,
		logic [7:0] i, logic [31:0] h);
		lpm_pkg::in_t it;
		it.func = f; it.address = a; it.prefix_len = l; it.iface_id = i; it.next_hop = h;
		return it;
	endfunction

	function automatic lpm_pkg::out_t status_only(logic [1:0] s);
		lpm_pkg::out_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

	// pick an address near a stored prefix so lookups hit often
	function automatic logic [31:0] near_addr();
		int k;
		k = int'($urandom_range(ENTRIES - 1));
		if (rt_valid[k] && $urandom_range(3) != 0)
			return rt_prefix[k] | ($urandom() & ~mask_of(rt_len[k]));
		return $urandom();
	endfunction

	initial begin
		row_t dir[$];
		row_t rw;
		lpm_pkg::in_t it;
		int op;
		logic [5:0] l;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		dflt_iface = 0;
		dflt_hop = 0;
		foreach (rt_valid[k]) rt_valid[k] = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed rows: typed-in results where obvious
		rw = '{lpm_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 1, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_DEL, 32'h0A00_0000, 8, 0, 0, 1,
			status_only(lpm_pkg::ST_ABSENT)};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_ADD, 32'h0A01_0203, 8, 8'hFF, 32'hFFFF_FFFF, 1,
			status_only(lpm_pkg::ST_DONE)};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_ADD, 32'h0AFF_FFFF, 8, 8'h01, 32'h1, 1,
			status_only(lpm_pkg::ST_DUP)};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_ADD, 32'hFFFF_FFFF, 0, 8'h55, 32'hAAAA_5555, 0, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_ADD, 32'h0A01_0203, 63, 8'hAA, 32'h5555_AAAA, 0, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_ADD, 32'h0A01_0203, 32, 8'h00, 32'h0, 1,
			status_only(lpm_pkg::ST_DUP)};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_LOOKUP, 32'h0A01_0203, 0, 0, 0, 0, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_LOOKUP, 32'h0A01_0204, 0, 0, 0, 0, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_LOOKUP, 32'h0000_0000, 0, 0, 0, 0, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_NONE, 32'hFFFF_FFFF, 6'h3F, 8'hFF, 32'hFFFF_FFFF, 1, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_DEL, 32'h0000_0000, 0, 0, 0, 1,
			status_only(lpm_pkg::ST_DONE)};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_DEL, 32'h0A01_0203, 40, 0, 0, 1,
			status_only(lpm_pkg::ST_DONE)};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_LOOKUP, 32'h0A01_0203, 0, 0, 0, 0, '0};
		dir.push_back(rw);
		rw = '{lpm_pkg::FUNC_LOOKUP, 32'h0B00_0000, 0, 0, 0, 1, '0};
		dir.push_back(rw);
		foreach (dir[n]) begin
			it = mk(dir[n].func, dir[n].address, dir[n].plen, dir[n].iface, dir[n].hop);
			send_beat(it, dir[n].typed, dir[n].want);
		end
		drain();

		// defaults at their extremes, then fill the table to overflow
		write_reg(lpm_pkg::CFG_DEFAULT_IFACE, 32'hFF);
		write_reg(lpm_pkg::CFG_DEFAULT_HOP, 32'hFFFF_FFFF);
		send_beat(mk(lpm_pkg::FUNC_LOOKUP, 32'h1234_5678, 6'd0, 8'd0, 32'd0), 0, '0);
		for (int n = 0; n < ENTRIES + 4; n++)
			send_beat(mk(lpm_pkg::FUNC_ADD, $urandom(), 6'($urandom_range(32)),
				8'($urandom()), $urandom()), 0, '0);
		drain();

		// hold-off: receiver blocks while the sender keeps offering
		fork
			begin
				sink_hold = 1;
				wait_cycles(200);
				sink_hold = 0;
			end
			begin
				for (int n = 0; n < 10; n++)
					send_beat(mk(lpm_pkg::FUNC_LOOKUP, near_addr(), 6'd0, 8'd0, 32'd0),
						0, '0);
				in_valid <= 0;
			end
		join
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			write_reg(lpm_pkg::CFG_DEFAULT_IFACE, phase == 0 ? 32'h0 : $urandom_range(255));
			write_reg(lpm_pkg::CFG_DEFAULT_HOP, phase == 0 ? 32'h0 : $urandom());
			calm = (phase == 2);
			for (int n = 0; n < 250; n++) begin
				op = $urandom_range(99);
				l = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) :
					6'($urandom_range(32));
				if (op < 45)
					it = mk(lpm_pkg::FUNC_LOOKUP, near_addr(), 6'($urandom()),
						8'($urandom()), $urandom());
				else if (op < 75)
					it = mk(lpm_pkg::FUNC_ADD, $urandom(), l, 8'($urandom()), $urandom());
				else if (op < 97)
					it = mk(lpm_pkg::FUNC_DEL, near_addr(), l, 8'($urandom()), $urandom());
				else
					it = mk(lpm_pkg::FUNC_NONE, $urandom(), 6'($urandom()),
						8'($urandom()), $urandom());
				// deletes of stored keys keep the table churning
				if (it.func == lpm_pkg::FUNC_DEL && $urandom_range(1)) begin
					op = int'($urandom_range(ENTRIES - 1));
					if (rt_valid[op]) begin
						it.address = rt_prefix[op] | ($urandom() & ~mask_of(rt_len[op]));
						it.prefix_len = rt_len[op];
					end
				end
				send_beat(it, 0, '0);
			end
			drain();
		end
		calm = 0;

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
